>>> rtl/core/sfp_pkg.sv
// Shared constants and types of the serial frame parser.
package sfp_pkg;

  localparam int unsigned PAYLOAD_BYTES = 8;
  localparam int unsigned NUM_SAMPLES   = PAYLOAD_BYTES / 2;
  localparam int unsigned CNT_W         = $clog2(PAYLOAD_BYTES + 1);
  localparam int unsigned IDX_W         = $clog2(PAYLOAD_BYTES);
  localparam logic [7:0]  SUM_SEED      = 8'd10;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PAYLOAD_BYTES-1:0][7:0] payload_t;

  // One finished frame handed from the parser to the result stage.
  typedef struct packed {
    logic     ok;
    payload_t payload;
  } frame_t;

endpackage

>>> rtl/core/sfp_front.sv
// Frame parser: start byte hunt, payload capture and checksum check.
module sfp_front import sfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_start_byte_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       full_i,
  output logic       push_o,
  output frame_t     push_data_o
);

  logic [7:0]       start_byte_q;
  logic             in_frame_q, in_frame_d;
  logic [CNT_W-1:0] byte_count_q, byte_count_d;
  logic [7:0]       sum_q, sum_d;
  payload_t         payload_q;
  logic             accept;
  logic             at_checksum;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign at_checksum = in_frame_q && (byte_count_q == CNT_W'(PAYLOAD_BYTES));

  assign push_o              = accept && at_checksum;
  assign push_data_o.ok      = (rx_byte_i == sum_q);
  assign push_data_o.payload = payload_q;

  always_comb begin
    in_frame_d   = in_frame_q;
    byte_count_d = byte_count_q;
    sum_d        = sum_q;
    if (accept) begin
      if (!in_frame_q) begin
        if (rx_byte_i == start_byte_q) begin
          in_frame_d   = 1'b1;
          byte_count_d = '0;
          sum_d        = SUM_SEED;
        end
      end else if (at_checksum) begin
        in_frame_d   = 1'b0;
        byte_count_d = '0;
        sum_d        = SUM_SEED;
      end else begin
        byte_count_d = byte_count_q + CNT_W'(1);
        sum_d        = sum_q + rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= '0;
      in_frame_q   <= 1'b0;
      byte_count_q <= '0;
      sum_q        <= SUM_SEED;
    end else begin
      if (cfg_valid_i) begin
        start_byte_q <= cfg_start_byte_i;
      end
      in_frame_q   <= in_frame_d;
      byte_count_q <= byte_count_d;
      sum_q        <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_frame_q && !at_checksum) begin
      payload_q[byte_count_q[IDX_W-1:0]] <= rx_byte_i;
    end
  end

endmodule

>>> rtl/core/sfp_queue.sv
// Short queue of finished frames between the parser and the result stage.
module sfp_queue import sfp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output frame_t pop_data_o
);

  frame_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o     = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/core/sfp_back.sv
// Result stage: sample unpacking, error counting and the output register.
module sfp_back import sfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  frame_t             frame_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               frame_ok_o,
  output logic signed [15:0] sample_0_o,
  output logic signed [15:0] sample_1_o,
  output logic signed [15:0] sample_2_o,
  output logic signed [15:0] sample_3_o,
  output logic [31:0]        error_count_o
);

  logic        valid_q;
  logic        ok_q;
  logic [31:0] errors_q, errors_d;
  logic [NUM_SAMPLES-1:0][15:0] samples_q, samples_d;

  assign pop_o = !empty_i && (!valid_q || out_ready_i);

  always_comb begin
    errors_d = frame_i.ok ? errors_q : errors_q + 32'd1;
    for (int k = 0; k < NUM_SAMPLES; k++) begin
      samples_d[k] = frame_i.ok ? {frame_i.payload[2*k+1], frame_i.payload[2*k]} : 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      errors_q <= '0;
    end else begin
      if (pop_o) begin
        valid_q  <= 1'b1;
        errors_q <= errors_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ok_q      <= frame_i.ok;
      samples_q <= samples_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign frame_ok_o    = ok_q;
  assign sample_0_o    = signed'(samples_q[0]);
  assign sample_1_o    = signed'(samples_q[1]);
  assign sample_2_o    = signed'(samples_q[2]);
  assign sample_3_o    = signed'(samples_q[3]);
  assign error_count_o = errors_q;

endmodule

>>> rtl/core/serial_frame_parser_checksum.sv
// Serial frame parser: hunts a start byte, checks an additive checksum, emits samples.
//
// Received bytes come in on the in channel (in_valid_i, in_ready_o, rx_byte_i),
// one request per cycle. The start byte is set through the cfg channel, which is
// always ready and takes effect from the next cycle. A frame is the start byte,
// eight payload bytes and one checksum byte equal to 10 plus the payload sum,
// modulo 256. Only the checksum byte produces a result on the out channel: frame_ok_o
// with four little-endian signed samples, or an error with zero samples and the
// bumped error_count_o. The parser writes the finished frame into a two-entry queue
// and the result stage moves it to the output register when that register is free or
// being read. Throughput is one byte per cycle while the queue is not full; the result
// stage drains one frame per cycle while the receiver is ready. When the receiver
// stalls, results wait in the output register and the queue; bytes keep being taken
// until the queue is full, and only then does in_ready_o drop. Reset returns the
// parser to hunting, clears the start byte, the error count and all valid state.
module serial_frame_parser_checksum import sfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_start_byte_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               frame_ok_o,
  output logic signed [15:0] sample_0_o,
  output logic signed [15:0] sample_1_o,
  output logic signed [15:0] sample_2_o,
  output logic signed [15:0] sample_3_o,
  output logic [31:0]        error_count_o
);

  logic   push, full, pop, empty;
  frame_t push_data, pop_data;

  sfp_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_start_byte_i (cfg_start_byte_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .full_i           (full),
    .push_o           (push),
    .push_data_o      (push_data)
  );

  sfp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  sfp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .frame_i       (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .frame_ok_o    (frame_ok_o),
    .sample_0_o    (sample_0_o),
    .sample_1_o    (sample_1_o),
    .sample_2_o    (sample_2_o),
    .sample_3_o    (sample_3_o),
    .error_count_o (error_count_o)
  );

endmodule

>>> verif/serial_frame_parser_checksum_test.sv
// Testbench for the serial frame parser: directed frames, back-pressure and random traffic.
`timescale 1ns / 100ps

module serial_frame_parser_checksum_test;
  import sfp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned RANDOM_BYTES   = 400;

  typedef struct packed {
    logic        ok;
    logic [15:0] s0;
    logic [15:0] s1;
    logic [15:0] s2;
    logic [15:0] s3;
    logic [31:0] errs;
  } frame_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [7:0]         cfg_start_byte_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         rx_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               frame_ok_o;
  logic signed [15:0] sample_0_o;
  logic signed [15:0] sample_1_o;
  logic signed [15:0] sample_2_o;
  logic signed [15:0] sample_3_o;
  logic [31:0]        error_count_o;

  // Parser state as the testbench tracks it.
  logic [7:0]  pr_start   = 8'h00;
  logic        pr_in_frame = 1'b0;
  int unsigned pr_count   = 0;
  logic [7:0]  pr_sum     = SUM_SEED;
  payload_t    pr_payload = '0;
  logic [31:0] pr_errors  = '0;

  frame_result_t frames_due[$];
  int unsigned   mismatches    = 0;
  int unsigned   idle_cycles   = 0;
  int unsigned   long_hold_req = 0;
  bit            in_idle_on    = 1'b0;
  bit            out_idle_on   = 1'b0;
  logic [7:0]    cur_start     = 8'h00;

  serial_frame_parser_checksum uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_start_byte_i (cfg_start_byte_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_ok_o       (frame_ok_o),
    .sample_0_o       (sample_0_o),
    .sample_1_o       (sample_1_o),
    .sample_2_o       (sample_2_o),
    .sample_3_o       (sample_3_o),
    .error_count_o    (error_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at %0t: %s got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic predict_byte(input logic [7:0] b);
    frame_result_t res;
    if (!pr_in_frame) begin
      if (b == pr_start) begin
        pr_in_frame = 1'b1;
        pr_count    = 0;
        pr_sum      = SUM_SEED;
      end
    end else if (pr_count < PAYLOAD_BYTES) begin
      pr_payload[pr_count] = b;
      pr_sum               = pr_sum + b;
      pr_count++;
    end else begin
      pr_in_frame = 1'b0;
      pr_count    = 0;
      if (b == pr_sum) begin
        res.ok = 1'b1;
        res.s0 = pr_payload[1:0];
        res.s1 = pr_payload[3:2];
        res.s2 = pr_payload[5:4];
        res.s3 = pr_payload[7:6];
      end else begin
        pr_errors = pr_errors + 32'd1;
        res.ok    = 1'b0;
        res.s0    = '0;
        res.s1    = '0;
        res.s2    = '0;
        res.s3    = '0;
      end
      res.errs = pr_errors;
      pr_sum   = SUM_SEED;
      frames_due.insert(frames_due.size(), res);
    end
  endtask

  // Results are checked before the byte of the same edge is predicted, so the
  // outcome never depends on process order.
  always @(posedge clk_i) begin : check_results
    frame_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (frames_due.size() == 0) begin
          report_mismatch("result with none pending", {31'b0, frame_ok_o}, '0);
        end else begin
          want = frames_due.pop_front();
          if (frame_ok_o !== want.ok) begin
            report_mismatch("frame_ok", {31'b0, frame_ok_o}, {31'b0, want.ok});
          end
          if (sample_0_o !== want.s0) begin
            report_mismatch("sample_0", {16'b0, sample_0_o}, {16'b0, want.s0});
          end
          if (sample_1_o !== want.s1) begin
            report_mismatch("sample_1", {16'b0, sample_1_o}, {16'b0, want.s1});
          end
          if (sample_2_o !== want.s2) begin
            report_mismatch("sample_2", {16'b0, sample_2_o}, {16'b0, want.s2});
          end
          if (sample_3_o !== want.s3) begin
            report_mismatch("sample_3", {16'b0, sample_3_o}, {16'b0, want.s3});
          end
          if (error_count_o !== want.errs) begin
            report_mismatch("error_count", error_count_o, want.errs);
          end
        end
      end
      if (in_valid_i && in_ready_o) predict_byte(rx_byte_i);
      if (cfg_valid_i && cfg_ready_o) pr_start = cfg_start_byte_i;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result receiver: random stalls, plus one long hold when requested.
  initial begin : receiver
    int unsigned rx_hold;
    rx_hold     = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold == 0 && long_hold_req != 0) begin
        rx_hold       = long_hold_req;
        long_hold_req = 0;
      end else if (rx_hold == 0 && out_idle_on && $urandom_range(0, 3) == 0) begin
        rx_hold = pick_gap();
      end
      if (rx_hold != 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = in_idle_on ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // A mask of zero gives a good checksum; any other mask corrupts it.
  task automatic send_frame(input payload_t p, input logic [7:0] mask);
    logic [7:0] sum;
    sum = SUM_SEED;
    send_byte(cur_start);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      sum = sum + p[i];
      send_byte(p[i]);
    end
    send_byte(sum ^ mask);
  endtask

  task automatic finish_phase();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_start(input logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i      <= 1'b1;
    cfg_start_byte_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_start   = value;
  endtask

  task automatic test_basic_frames();
    // Start byte is zero after reset; the samples carry both signs.
    send_frame(64'hFFFF_0001_7F80_FF00, 8'h00);
    send_byte(8'h55);
    // All-zero payload carries the start byte; checksum equal to start byte is wrong.
    send_frame('0, 8'h0A);
    finish_phase();
  endtask

  task automatic test_start_byte_extremes();
    logic [7:0] sum;
    logic [7:0] b;
    write_start(8'hFF);
    send_byte(8'h00);
    send_frame('1, 8'h00);
    send_frame(64'h8000_7FFF_0102_0408, 8'h80);
    finish_phase();
    // Change the start byte while the parser is in the middle of a frame.
    write_start(8'hA5);
    sum = SUM_SEED;
    send_byte(8'hA5);
    for (int i = 0; i < 3; i++) begin
      b   = 8'($urandom_range(0, 255));
      sum = sum + b;
      send_byte(b);
    end
    finish_phase();
    write_start(8'h00);
    for (int i = 0; i < 5; i++) begin
      b   = (i == 0) ? 8'hA5 : 8'($urandom_range(0, 255));
      sum = sum + b;
      send_byte(b);
    end
    send_byte(sum);
    finish_phase();
  endtask

  task automatic test_backpressure();
    in_idle_on    = 1'b0;
    out_idle_on   = 1'b0;
    long_hold_req = 300;
    for (int i = 0; i < 6; i++) begin
      send_frame({$urandom, $urandom}, (i == 3) ? 8'h01 : 8'h00);
    end
    finish_phase();
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned phase;
    int unsigned r;
    int unsigned n;
    logic [7:0]  mask;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_BYTES) begin
      case (phase % 4)
        0:       write_start(8'h00);
        1:       write_start(8'hFF);
        default: write_start(8'($urandom_range(0, 255)));
      endcase
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(3, 10)) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          mask = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
          send_frame({$urandom, $urandom}, mask);
          sent += PAYLOAD_BYTES + 2;
        end else if (r < 88) begin
          // Line noise between frames.
          n = $urandom_range(1, 4);
          repeat (n) send_byte(8'($urandom_range(0, 255)));
          sent += n;
        end else begin
          // Frame cut short; the next start byte lands in its payload.
          n = $urandom_range(0, PAYLOAD_BYTES - 1);
          send_byte(cur_start);
          repeat (n) send_byte(8'($urandom_range(0, 255)));
          sent += n + 1;
        end
      end
      finish_phase();
      phase++;
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_start_byte_i = 8'h00;
    in_valid_i       = 1'b0;
    rx_byte_i        = 8'h00;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_basic_frames();
    test_start_byte_extremes();
    test_backpressure();
    test_random_traffic();
    finish_phase();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/sfp_pkg.sv
rtl/core/sfp_front.sv
rtl/core/sfp_queue.sv
rtl/core/sfp_back.sv
rtl/core/serial_frame_parser_checksum.sv
verif/serial_frame_parser_checksum_test.sv
